FILE: design/valid_slot_table_engine_assert.svh
// Assertion macros for the valid slot table engine checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef VALID_SLOT_TABLE_ENGINE_ASSERT_SVH
`define VALID_SLOT_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VSTE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VSTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/vste_pkg.sv
// Package for the valid slot table engine: sizes, operation codes, shared
// types and field conversion functions. Depends on nothing.
`default_nettype none

package vste_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int VALUE_WIDTH = 16;

  localparam int IDX_W   = $clog2(SLOT_COUNT);
  localparam int COUNT_W = $clog2(SLOT_COUNT + 1);

  // Fixed widths of the request and response fields.
  localparam int KIND_W    = 2;
  localparam int OPERAND_W = 16;
  localparam int MCOUNT_W  = 5;
  localparam int LARGEST_W = 16;
  localparam int VCOUNT_W  = 5;

  localparam logic [KIND_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] OP_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] OP_INSERT = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef struct packed {
    logic                   value_we;
    logic                   valid_set;
    logic                   valid_clr;
    logic [IDX_W-1:0]       addr;
    logic [VALUE_WIDTH-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic                   hit;
    logic                   take;
    logic                   post_valid;
    logic [VALUE_WIDTH-1:0] post_value;
    logic                   bigger;
  } cmp_t;

  typedef struct packed {
    logic [MCOUNT_W-1:0]  match_count;
    logic                 failed;
    logic [LARGEST_W-1:0] largest_value;
    logic [VCOUNT_W-1:0]  valid_count;
  } res_t;

  function automatic logic [VALUE_WIDTH-1:0] value_from_field(
      input logic [OPERAND_W-1:0] f);
    logic [31:0] t;
    t = 32'(f);
    return t[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic [LARGEST_W-1:0] value_to_field(
      input logic [VALUE_WIDTH-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[LARGEST_W-1:0];
  endfunction

  function automatic logic [MCOUNT_W-1:0] count_to_field(
      input logic [COUNT_W-1:0] c);
    logic [31:0] t;
    t = 32'(c);
    return t[MCOUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/vste_if.sv
// Request and response channel interfaces of the valid slot table engine.
// Depends on vste_pkg for the field widths.
`default_nettype none

interface vste_req_if;
  logic                          valid;
  logic                          ready;
  logic [vste_pkg::KIND_W-1:0]    kind;
  logic [vste_pkg::OPERAND_W-1:0] operand_value;

  modport source (output valid, output kind, output operand_value, input ready);
  modport sink   (input valid, input kind, input operand_value, output ready);
endinterface

interface vste_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [vste_pkg::MCOUNT_W-1:0]  match_count;
  logic                          failed;
  logic [vste_pkg::LARGEST_W-1:0] largest_value;
  logic [vste_pkg::VCOUNT_W-1:0]  valid_count;

  modport source (output valid, output match_count, output failed,
                  output largest_value, output valid_count, input ready);
  modport sink   (input valid, input match_count, input failed,
                  input largest_value, input valid_count, output ready);
endinterface

`default_nettype wire

FILE: design/vste_table.sv
// Slot storage: value memory with registered read and per-slot valid flags.
// Depends on vste_pkg.
`default_nettype none

module vste_table (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [vste_pkg::IDX_W-1:0]       rd_addr,
  input  wire vste_pkg::wr_req_t                wr,
  output      logic                            rd_valid,
  output      logic [vste_pkg::VALUE_WIDTH-1:0] rd_value
);
  import vste_pkg::*;

  logic [VALUE_WIDTH-1:0] mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  valid;

  // Stale values behind a clear flag are never observed, so no reset here.
  always_ff @(posedge clk) begin
    if (wr.value_we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_value <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.valid_set) begin
        valid[wr.addr] <= 1'b1;
      end else if (wr.valid_clr) begin
        valid[wr.addr] <= 1'b0;
      end
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/vste_cmp.sv
// Shared compare unit: evaluates one slot against the current operation.
// Depends on vste_pkg.
`default_nettype none

module vste_cmp (
  input  wire logic [vste_pkg::KIND_W-1:0]      op,
  input  wire logic [vste_pkg::VALUE_WIDTH-1:0] operand,
  input  wire logic                            placed,
  input  wire logic [vste_pkg::VALUE_WIDTH-1:0] largest,
  input  wire logic                            slot_valid,
  input  wire logic [vste_pkg::VALUE_WIDTH-1:0] slot_value,
  output      vste_pkg::cmp_t                   res
);
  import vste_pkg::*;

  logic equal;

  always_comb begin
    equal    = (slot_value == operand);
    res.hit  = slot_valid && equal && (op == OP_LOOKUP || op == OP_DELETE);
    res.take = (op == OP_INSERT) && !slot_valid && !placed;
    if (op == OP_DELETE) begin
      res.post_valid = slot_valid && !res.hit;
    end else begin
      res.post_valid = slot_valid || res.take;
    end
    res.post_value = res.take ? operand : slot_value;
    res.bigger     = res.post_valid && (res.post_value > largest);
  end

endmodule

`default_nettype wire

FILE: design/vste_seq.sv
// Sequencer: steps the shared compare unit over every slot once per request
// and gathers the counts and the maximum. Depends on vste_pkg and vste_cmp.
`default_nettype none

module vste_seq (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  input  wire logic [vste_pkg::KIND_W-1:0]      req_kind,
  input  wire logic [vste_pkg::OPERAND_W-1:0]   req_operand,
  output      logic                            req_ready,
  input  wire logic                            rd_valid,
  input  wire logic [vste_pkg::VALUE_WIDTH-1:0] rd_value,
  output      logic [vste_pkg::IDX_W-1:0]       rd_addr,
  output      vste_pkg::wr_req_t                wr,
  input  wire logic                            out_free,
  output      logic                            res_load,
  output      vste_pkg::res_t                   res
);
  import vste_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                 state, state_next;
  logic [IDX_W-1:0]       idx;
  logic [KIND_W-1:0]      op;
  logic [VALUE_WIDTH-1:0] operand;
  logic [COUNT_W-1:0]     hit_count;
  logic [COUNT_W-1:0]     nvalid;
  logic [VALUE_WIDTH-1:0] largest;
  logic                   placed;
  cmp_t                   cmp;
  logic                   accept;

  vste_cmp u_cmp (
    .op         (op),
    .operand    (operand),
    .placed     (placed),
    .largest    (largest),
    .slot_valid (rd_valid),
    .slot_value (rd_value),
    .res        (cmp)
  );

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign res_load  = (state == ST_DONE) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_SCAN;
      ST_SCAN: if (idx == LAST_IDX) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Read one slot ahead of the one being evaluated.
  always_comb begin
    if (state == ST_SCAN && idx != LAST_IDX) begin
      rd_addr = idx + IDX_W'(1);
    end else begin
      rd_addr = '0;
    end
    wr.addr      = idx;
    wr.data      = operand;
    wr.value_we  = (state == ST_SCAN) && cmp.take;
    wr.valid_set = (state == ST_SCAN) && cmp.take;
    wr.valid_clr = (state == ST_SCAN) && cmp.hit && (op == OP_DELETE);
  end

  always_comb begin
    res.match_count   = count_to_field(hit_count);
    res.failed        = ((op == OP_DELETE) && (hit_count == '0)) ||
                        ((op == OP_INSERT) && !placed);
    res.largest_value = value_to_field(largest);
    res.valid_count   = count_to_field(nvalid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= req_kind;
      operand   <= value_from_field(req_operand);
      idx       <= '0;
      hit_count <= '0;
      nvalid    <= '0;
      largest   <= '0;
      placed    <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (idx != LAST_IDX) begin
        idx <= idx + IDX_W'(1);
      end
      hit_count <= hit_count + COUNT_W'(cmp.hit);
      nvalid    <= nvalid + COUNT_W'(cmp.post_valid);
      if (cmp.bigger) begin
        largest <= cmp.post_value;
      end
      placed <= placed || cmp.take;
    end
  end

endmodule

`default_nettype wire

FILE: design/valid_slot_table_engine.sv
// Top level of the valid slot table engine: slot storage, sequencer with its
// shared compare unit, and the response register. Depends on vste_pkg, vste_if.
`default_nettype none

// The engine keeps a table of SLOT_COUNT slots, each a value with a valid
// flag, and serves one request at a time: a lookup counts the valid slots
// equal to the operand, a delete clears every valid slot equal to it and
// reports how many went, and an insert writes it into the lowest empty slot.
// Every response also carries the largest valid value (zero for an empty
// table) and the number of valid slots, both as they stand after the request.
// Kind code 3 leaves the table alone and just reports the two summaries.
// A request occupies the block for a scan over every slot in turn on a
// single equality and magnitude comparator fed from the value memory's one
// read port, then the state that posts the response and the idle state in
// which the next request is taken. The request side is ready again while
// an earlier response still waits in the output register; only when that
// register is still full at the end of a scan does the block hold the
// finished response and stay busy. Reset empties the table at once through
// its valid flags, so there is no clearing pass.
module valid_slot_table_engine (
  input wire logic clk,
  input wire logic rst,
  vste_req_if.sink req,
  vste_rsp_if.source rsp
);
  import vste_pkg::*;

  logic                   rd_valid;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic [IDX_W-1:0]       rd_addr;
  wr_req_t                wr;
  logic                   out_free;
  logic                   res_load;
  res_t                   res;
  res_t                   out_reg;
  logic                   out_valid;

  vste_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .rd_valid (rd_valid),
    .rd_value (rd_value)
  );

  vste_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_kind    (req.kind),
    .req_operand (req.operand_value),
    .req_ready   (req.ready),
    .rd_valid    (rd_valid),
    .rd_value    (rd_value),
    .rd_addr     (rd_addr),
    .wr          (wr),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res)
  );

  // The response register is free when empty or being emptied this cycle.
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_reg <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.match_count   = out_reg.match_count;
  assign rsp.failed        = out_reg.failed;
  assign rsp.largest_value = out_reg.largest_value;
  assign rsp.valid_count   = out_reg.valid_count;

endmodule

`default_nettype wire

FILE: design/vste_checker.sv
// Port-level checks for the valid slot table engine, bound to its top level.
// Depends on vste_pkg and valid_slot_table_engine_assert.svh.
`default_nettype none
`include "valid_slot_table_engine_assert.svh"

module vste_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic [vste_pkg::MCOUNT_W-1:0]    rsp_match_count,
  input wire logic                            rsp_failed,
  input wire logic [vste_pkg::VCOUNT_W-1:0]    rsp_valid_count
);
  import vste_pkg::*;

  `VSTE_ASSERT_NEXT(a_busy_after_request, req_valid && req_ready, !req_ready, "engine took a request while scanning")
  `VSTE_ASSERT_SAME(a_failed_no_matches, rsp_valid && rsp_failed, rsp_match_count == '0, "failed response reports matches")
  `VSTE_ASSERT_SAME(a_valid_count_bound, rsp_valid, 32'(rsp_valid_count) <= SLOT_COUNT, "valid count above table size")
  `VSTE_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid, "response dropped before it was taken")

endmodule

bind valid_slot_table_engine vste_checker u_vste_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_match_count (rsp.match_count),
  .rsp_failed      (rsp.failed),
  .rsp_valid_count (rsp.valid_count)
);

`default_nettype wire
